FILE: rtl/stack_register_instruction_executor_assert.svh
// Assertion macros shared by the stack register instruction executor RTL.
`ifndef STACK_REGISTER_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define STACK_REGISTER_INSTRUCTION_EXECUTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SRIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SRIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/srie_pkg.sv
// Package: widths, opcodes and status codes of the stack register instruction executor.
`timescale 1ns / 1ps
package srie_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int NUM_REGS        = 4;
  localparam int REG_SEL_W       = $clog2(NUM_REGS);
  localparam int KIND_W          = 8;
  localparam int REG_IDX_W       = 3;
  localparam int VALUE_W         = 32;
  localparam int TARGET_W        = 16;
  localparam int STATUS_W        = 3;

  // Opcodes
  localparam logic [KIND_W-1:0] OP_PUSH_REG = 8'd0;
  localparam logic [KIND_W-1:0] OP_PUSH_IMM = 8'd1;
  localparam logic [KIND_W-1:0] OP_POP_REG  = 8'd2;
  localparam logic [KIND_W-1:0] OP_ADD      = 8'd3;
  localparam logic [KIND_W-1:0] OP_MOVE     = 8'd4;
  localparam logic [KIND_W-1:0] OP_JUMP     = 8'd7;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_HALTED    = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_BADREG    = 3'd4
  } status_t;

  typedef logic [VALUE_W-1:0] value_t;

endpackage

FILE: rtl/srie_in_if.sv
// Interface: instruction channel (valid/ready plus decoded instruction fields).
`timescale 1ns / 1ps
interface srie_in_if;
  import srie_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [KIND_W-1:0]           kind;
  logic [REG_IDX_W-1:0]        reg_a;
  logic [REG_IDX_W-1:0]        reg_b;
  logic signed [VALUE_W-1:0]   immediate;
  logic [TARGET_W-1:0]         jump_target;

  modport source (output valid, kind, reg_a, reg_b, immediate, jump_target, input ready);
  modport sink   (input valid, kind, reg_a, reg_b, immediate, jump_target, output ready);
endinterface

FILE: rtl/srie_out_if.sv
// Interface: result channel (valid/ready plus status, jump report and registers).
`timescale 1ns / 1ps
interface srie_out_if;
  import srie_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [STATUS_W-1:0]         status;
  logic                        jump_taken;
  logic [TARGET_W-1:0]         jump_address;
  logic signed [VALUE_W-1:0]   reg0_value;
  logic signed [VALUE_W-1:0]   reg1_value;
  logic signed [VALUE_W-1:0]   reg2_value;
  logic signed [VALUE_W-1:0]   reg3_value;

  modport source (output valid, status, jump_taken, jump_address,
                  reg0_value, reg1_value, reg2_value, reg3_value, input ready);
  modport sink   (input valid, status, jump_taken, jump_address,
                  reg0_value, reg1_value, reg2_value, reg3_value, output ready);
endinterface

FILE: rtl/srie_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module srie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/stack_register_instruction_executor.sv
// Top level: executes one decoded instruction per transaction on four registers and a stack.
`timescale 1ns / 1ps
// Executes one decoded instruction per transaction against four 32-bit Q16.16
// registers and a value stack of STACK_DEPTH entries, and returns one result
// per instruction: a status code, the jump report and all four registers after
// the step. Throughput is one instruction per clock while the result channel
// is not stalled. The instruction is held in an input register and executed
// into the result register, so one instruction can be taken while a result is
// still waiting at the output. The stack lives in a RAM with registered read;
// its top entry is kept in a register and the entry below it is prefetched,
// which lets pops run back to back. The stack needs no clearing after reset.
// An undefined opcode halts the block until reset; from then on each
// instruction answers "halted" and changes nothing.
module stack_register_instruction_executor #(
  parameter int STACK_DEPTH = srie_pkg::STACK_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  srie_in_if.sink   in_ch,
  srie_out_if.source out_ch
);
  import srie_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  // Input register
  logic                  in_v_r;
  logic [KIND_W-1:0]     kind_r;
  logic [REG_IDX_W-1:0]  ra_r;
  logic [REG_IDX_W-1:0]  rb_r;
  value_t                imm_r;
  logic [TARGET_W-1:0]   tgt_r;

  // Result register
  logic                  out_v_r;
  status_t               status_r, status_nxt;
  logic                  jt_r, jt_nxt;
  logic [TARGET_W-1:0]   ja_r, ja_nxt;

  // Architectural state
  value_t                regs_r [NUM_REGS];
  value_t                regs_nxt [NUM_REGS];
  logic [CW-1:0]         cnt_r, cnt_nxt;
  value_t                tos_r, tos_nxt;
  logic                  halted_r, halted_nxt;

  // Stack RAM port
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  value_t                ram_wdata;
  logic [AW-1:0]         ram_raddr;
  value_t                ram_rdata;

  logic                  exec;
  logic                  a_ok, b_ok;
  logic                  full, empty;
  value_t                val_a, val_b;

  // Handshake: execute when the result slot is free or being emptied
  assign exec        = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || exec;

  assign a_ok  = ra_r < REG_IDX_W'(NUM_REGS);
  assign b_ok  = rb_r < REG_IDX_W'(NUM_REGS);
  assign full  = cnt_r == CW'(STACK_DEPTH);
  assign empty = cnt_r == '0;
  assign val_a = regs_r[ra_r[REG_SEL_W-1:0]];
  assign val_b = regs_r[rb_r[REG_SEL_W-1:0]];

  // Instruction execute
  always_comb begin
    regs_nxt   = regs_r;
    cnt_nxt    = cnt_r;
    tos_nxt    = tos_r;
    halted_nxt = halted_r;
    status_nxt = ST_OK;
    jt_nxt     = 1'b0;
    ja_nxt     = '0;
    ram_we     = 1'b0;
    ram_waddr  = cnt_r[AW-1:0];
    ram_wdata  = val_a;
    if (exec) begin
      if (halted_r) begin
        status_nxt = ST_HALTED;
      end else begin
        unique case (kind_r)
          OP_PUSH_REG, OP_PUSH_IMM: begin
            ram_wdata = (kind_r == OP_PUSH_IMM) ? imm_r : val_a;
            if (kind_r == OP_PUSH_REG && !a_ok) begin
              status_nxt = ST_BADREG;
            end else if (full) begin
              status_nxt = ST_OVERFLOW;
            end else begin
              ram_we  = 1'b1;
              tos_nxt = ram_wdata;
              cnt_nxt = cnt_r + CW'(1);
            end
          end
          OP_POP_REG: begin
            if (!a_ok) begin
              status_nxt = ST_BADREG;
            end else if (empty) begin
              status_nxt = ST_UNDERFLOW;
            end else begin
              regs_nxt[ra_r[REG_SEL_W-1:0]] = tos_r;
              tos_nxt = ram_rdata;  // entry below the top, fetched last cycle
              cnt_nxt = cnt_r - CW'(1);
            end
          end
          OP_ADD: begin
            if (!a_ok || !b_ok) begin
              status_nxt = ST_BADREG;
            end else begin
              regs_nxt[ra_r[REG_SEL_W-1:0]] = val_a + val_b;  // wraps mod 2^32
            end
          end
          OP_MOVE: begin
            if (!a_ok || !b_ok) begin
              status_nxt = ST_BADREG;
            end else begin
              regs_nxt[ra_r[REG_SEL_W-1:0]] = val_b;
            end
          end
          OP_JUMP: begin
            jt_nxt = 1'b1;
            ja_nxt = tgt_r;
          end
          default: begin
            halted_nxt = 1'b1;
            status_nxt = ST_HALTED;
          end
        endcase
      end
    end
  end

  // Prefetch the entry below the new top so a following pop finds it
  always_comb begin
    ram_raddr = '0;
    if (cnt_nxt >= CW'(2)) begin
      ram_raddr = AW'(cnt_nxt - CW'(2));
    end
  end

  srie_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control state, registers and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      cnt_r    <= '0;
      halted_r <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      in_v_r   <= (in_ch.valid && in_ch.ready) || (in_v_r && !exec);
      cnt_r    <= cnt_nxt;
      halted_r <= halted_nxt;
      regs_r   <= regs_nxt;
      if (exec) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    if (in_ch.valid && in_ch.ready) begin
      kind_r <= in_ch.kind;
      ra_r   <= in_ch.reg_a;
      rb_r   <= in_ch.reg_b;
      imm_r  <= in_ch.immediate;
      tgt_r  <= in_ch.jump_target;
    end
    if (exec) begin
      status_r <= status_nxt;
      jt_r     <= jt_nxt;
      ja_r     <= ja_nxt;
    end
  end

  // Registers change only on execute, which also reloads the result register
  assign out_ch.valid        = out_v_r;
  assign out_ch.status       = status_r;
  assign out_ch.jump_taken   = jt_r;
  assign out_ch.jump_address = ja_r;
  assign out_ch.reg0_value   = regs_r[0];
  assign out_ch.reg1_value   = regs_r[1];
  assign out_ch.reg2_value   = regs_r[2];
  assign out_ch.reg3_value   = regs_r[3];

  // Checks
  `include "stack_register_instruction_executor_assert.svh"

  `SRIE_ASSERT_NOW(a_count_bound, 1'b1, cnt_r <= CW'(STACK_DEPTH), "stack count above depth")
  `SRIE_ASSERT_NEXT(a_halt_sticky, halted_r, halted_r, "halt flag cleared without reset")
  `SRIE_ASSERT_NOW(a_overflow_full, out_v_r && status_r == ST_OVERFLOW, full, "overflow while not full")
  `SRIE_ASSERT_NOW(a_jump_ok, out_v_r && jt_r, status_r == ST_OK && !halted_r, "bad jump report")

endmodule

FILE: tb/tb_top.sv
// Testbench top: drives instruction streams into the executor and checks every result.
`timescale 1ns / 1ps
module tb_top;
  import srie_pkg::*;

  localparam int DEPTH        = STACK_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 600;
  localparam int LONG_HOLD    = 400;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [REG_IDX_W-1:0] reg_a;
    logic [REG_IDX_W-1:0] reg_b;
    value_t               immediate;
    logic [TARGET_W-1:0]  jump_target;
  } instr_t;

  typedef struct packed {
    status_t               status;
    logic                  jump_taken;
    logic [TARGET_W-1:0]   jump_address;
    value_t [NUM_REGS-1:0] regs;
  } exec_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  srie_in_if  in_bus ();
  srie_out_if out_bus ();

  stack_register_instruction_executor dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #2 clk = ~clk;

  // Machine state as the predictor sees it
  value_t      gp_regs [NUM_REGS] = '{default: '0};
  value_t      stack_mem [DEPTH];
  int unsigned stack_fill = 0;
  bit          halted     = 1'b0;

  logic [KIND_W-1:0] legal_ops [6] = '{OP_PUSH_REG, OP_PUSH_IMM, OP_POP_REG,
                                       OP_ADD, OP_MOVE, OP_JUMP};

  instr_t       pending_instrs [$];
  exec_result_t expected_results [$];
  int           total_instrs    = 0;
  int           accepted_instrs = 0;
  int           failures        = 0;

  // Push onto the modeled stack; a full stack drops the value
  function automatic status_t model_push(value_t v);
    if (stack_fill >= DEPTH) return ST_OVERFLOW;
    stack_mem[stack_fill] = v;
    stack_fill++;
    return ST_OK;
  endfunction

  // Run one instruction on the modeled machine and return what the block should answer
  function automatic exec_result_t execute_instr(instr_t ins);
    exec_result_t r;
    logic bad_a;
    logic bad_b;
    logic [REG_SEL_W-1:0] a;
    logic [REG_SEL_W-1:0] b;
    r        = '0;
    r.status = ST_OK;
    bad_a    = ins.reg_a >= NUM_REGS;
    bad_b    = ins.reg_b >= NUM_REGS;
    a        = ins.reg_a[REG_SEL_W-1:0];
    b        = ins.reg_b[REG_SEL_W-1:0];
    if (halted) begin
      r.status = ST_HALTED;
    end else begin
      case (ins.kind)
        OP_PUSH_REG: begin
          if (bad_a) r.status = ST_BADREG;
          else r.status = model_push(gp_regs[a]);
        end
        OP_PUSH_IMM: r.status = model_push(ins.immediate);
        OP_POP_REG: begin
          if (bad_a) begin
            r.status = ST_BADREG;
          end else if (stack_fill == 0) begin
            r.status = ST_UNDERFLOW;
          end else begin
            stack_fill--;
            gp_regs[a] = stack_mem[stack_fill];
          end
        end
        OP_ADD: begin
          if (bad_a || bad_b) r.status = ST_BADREG;
          else gp_regs[a] = gp_regs[a] + gp_regs[b];
        end
        OP_MOVE: begin
          if (bad_a || bad_b) r.status = ST_BADREG;
          else gp_regs[a] = gp_regs[b];
        end
        OP_JUMP: begin
          r.jump_taken   = 1'b1;
          r.jump_address = ins.jump_target;
        end
        default: begin
          halted   = 1'b1;
          r.status = ST_HALTED;
        end
      endcase
    end
    for (int i = 0; i < NUM_REGS; i++) r.regs[i] = gp_regs[i];
    return r;
  endfunction

  // Stimulus helpers
  function automatic void add_instr(logic [KIND_W-1:0] kind, int a, int b, value_t imm,
                                    int tgt);
    instr_t ins;
    ins.kind        = kind;
    ins.reg_a       = a[REG_IDX_W-1:0];
    ins.reg_b       = b[REG_IDX_W-1:0];
    ins.immediate   = imm;
    ins.jump_target = tgt[TARGET_W-1:0];
    pending_instrs.push_back(ins);
  endfunction

  // Mostly valid register index, sometimes one of the illegal ones
  function automatic int rand_idx();
    if ($urandom_range(0, 9) == 0) return $urandom_range(4, 7);
    return $urandom_range(0, 3);
  endfunction

  function automatic value_t rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return {8'hFF, 8'($urandom_range(0, 255)), 16'h0000};
      3:       return {16'($urandom_range(0, 15)), 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // One random instruction of the given opcode, with random side fields
  function automatic void add_random_op(logic [KIND_W-1:0] kind, bit wild_idx);
    int a;
    int b;
    a = wild_idx ? $urandom_range(0, 7) : rand_idx();
    b = wild_idx ? $urandom_range(0, 7) : rand_idx();
    if (kind == OP_PUSH_IMM || kind == OP_JUMP) begin
      a = $urandom_range(0, 7);
      b = $urandom_range(0, 7);
    end
    add_instr(kind, a, b, rand_value(), $urandom_range(0, 65535));
  endfunction

  // Push and pop runs, mostly with legal indices, deep enough to hit both stack limits, plus mixed noise
  task automatic build_random_part();
    int len;
    for (int i = 0; i < DEPTH + 3; i++)
      add_random_op($urandom_range(0, 1) ? OP_PUSH_IMM : OP_PUSH_REG, 1'b0);
    for (int i = 0; i < DEPTH + 3; i++) add_random_op(OP_POP_REG, 1'b0);
    while (pending_instrs.size() < RANDOM_ITEMS - 60) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          len = $urandom_range(1, DEPTH + 4);
          for (int i = 0; i < len; i++)
            add_random_op($urandom_range(0, 1) ? OP_PUSH_IMM : OP_PUSH_REG, 1'b0);
        end
        2, 3: begin
          len = $urandom_range(1, DEPTH + 4);
          for (int i = 0; i < len; i++) add_random_op(OP_POP_REG, 1'b0);
        end
        9: begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) add_random_op(legal_ops[$urandom_range(0, 5)], 1'b1);
        end
        default: begin
          len = $urandom_range(1, 12);
          for (int i = 0; i < len; i++) add_random_op(legal_ops[$urandom_range(0, 5)], 1'b0);
        end
      endcase
    end
  endtask

  // Stimulus and end of run
  initial begin
    logic [KIND_W-1:0] halt_kind;
    bit                legal;
    in_bus.valid       = 1'b0;
    in_bus.kind        = '0;
    in_bus.reg_a       = '0;
    in_bus.reg_b       = '0;
    in_bus.immediate   = '0;
    in_bus.jump_target = '0;
    out_bus.ready      = 1'b0;

    // Directed: limits of values, wrapping add, each opcode, bad indices
    add_instr(OP_POP_REG,  0, 0, '0, 0);               // pop on empty stack
    add_instr(OP_PUSH_IMM, 0, 0, 32'h7FFF_FFFF, 0);
    add_instr(OP_PUSH_IMM, 0, 0, 32'h8000_0000, 0);
    add_instr(OP_POP_REG,  1, 0, '0, 0);
    add_instr(OP_POP_REG,  0, 0, '0, 0);
    add_instr(OP_ADD,      0, 0, '0, 0);               // wraps positive
    add_instr(OP_ADD,      1, 1, '0, 0);               // wraps negative to zero
    add_instr(OP_PUSH_IMM, 0, 0, 32'hFFFF_FFFF, 0);
    add_instr(OP_POP_REG,  3, 0, '0, 0);
    add_instr(OP_MOVE,     2, 3, '0, 0);
    add_instr(OP_PUSH_REG, 2, 0, '0, 0);
    add_instr(OP_PUSH_REG, 3, 0, '0, 0);
    add_instr(OP_POP_REG,  2, 0, '0, 0);
    add_instr(OP_JUMP,     0, 0, '0, 0);
    add_instr(OP_JUMP,     7, 7, 32'h1234_5678, 16'hFFFF);
    add_instr(OP_PUSH_IMM, 7, 7, 32'h0001_0000, 16'hFFFF);
    add_instr(OP_PUSH_REG, 4, 0, '0, 0);
    add_instr(OP_POP_REG,  5, 0, '0, 0);               // bad index wins over a full-enough stack
    add_instr(OP_ADD,      6, 0, '0, 0);
    add_instr(OP_ADD,      0, 7, '0, 0);
    add_instr(OP_MOVE,     7, 1, '0, 0);
    add_instr(OP_MOVE,     1, 4, '0, 0);
    add_instr(OP_POP_REG,  0, 0, '0, 0);
    add_instr(OP_POP_REG,  1, 0, '0, 0);
    add_instr(OP_POP_REG,  4, 0, '0, 0);               // bad index wins over empty stack

    build_random_part();

    // Undefined opcode halts the block; everything after it is ignored
    do begin
      halt_kind = KIND_W'($urandom_range(0, 255));
      legal     = 1'b0;
      foreach (legal_ops[i]) if (legal_ops[i] == halt_kind) legal = 1'b1;
    end while (legal);
    add_instr(halt_kind, rand_idx(), rand_idx(), rand_value(), $urandom_range(0, 65535));
    foreach (legal_ops[i]) add_random_op(legal_ops[i], 1'b0);
    add_instr(8'hFF, 7, 7, 32'hFFFF_FFFF, 16'hFFFF);
    for (int i = 0; i < 16; i++)
      add_instr(KIND_W'($urandom_range(0, 255)), $urandom_range(0, 7), $urandom_range(0, 7),
                rand_value(), $urandom_range(0, 65535));
    total_instrs = pending_instrs.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_instrs < total_instrs) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Driver: bursts of transactions separated by random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    instr_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        nxt.kind        = in_bus.kind;
        nxt.reg_a       = in_bus.reg_a;
        nxt.reg_b       = in_bus.reg_b;
        nxt.immediate   = in_bus.immediate;
        nxt.jump_target = in_bus.jump_target;
        expected_results.push_back(execute_instr(nxt));
        accepted_instrs++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0 || pending_instrs.size() == 0) begin
          in_bus.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          nxt = pending_instrs.pop_front();
          in_bus.valid       <= 1'b1;
          in_bus.kind        <= nxt.kind;
          in_bus.reg_a       <= nxt.reg_a;
          in_bus.reg_b       <= nxt.reg_b;
          in_bus.immediate   <= nxt.immediate;
          in_bus.jump_target <= nxt.jump_target;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Compare one result against the oldest outstanding expectation
  task automatic check_result(exec_result_t got);
    exec_result_t want;
    if (expected_results.size() == 0) begin
      $error("result transaction arrived with no instruction outstanding");
      failures++;
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      failures++;
    end
    if (got.jump_taken !== want.jump_taken) begin
      $error("jump_taken: expected %0d, actual %0d", want.jump_taken, got.jump_taken);
      failures++;
    end
    if (got.jump_address !== want.jump_address) begin
      $error("jump_address: expected %h, actual %h", want.jump_address, got.jump_address);
      failures++;
    end
    for (int i = 0; i < NUM_REGS; i++) begin
      if (got.regs[i] !== want.regs[i]) begin
        $error("reg%0d_value: expected %h, actual %h", i, want.regs[i], got.regs[i]);
        failures++;
      end
    end
  endtask

  // Monitor: checks results, stalls on a rotating pattern, holds off once for a long stretch
  int rx_cycle     = 0;
  int results_seen = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  always @(posedge clk) begin
    exec_result_t got;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.status       = status_t'(out_bus.status);
        got.jump_taken   = out_bus.jump_taken;
        got.jump_address = out_bus.jump_address;
        got.regs[0]      = out_bus.reg0_value;
        got.regs[1]      = out_bus.reg1_value;
        got.regs[2]      = out_bus.reg2_value;
        got.regs[3]      = out_bus.reg3_value;
        check_result(got);
        results_seen++;
      end
      rx_cycle++;
      if (!hold_done && results_seen >= 150) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        case ((rx_cycle / 200) % 3)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= !((rx_cycle % 5) == 2 || (rx_cycle % 11) == 0);
          default: out_bus.ready <= ($urandom_range(0, 9) >= 4);
        endcase
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
